[src/tmc_pkg.sv]
// Shared constants and register codes for the throttle to motor current unit.
package tmc_pkg;

  localparam int ADC_BITS  = 10;
  localparam int TIME_BITS = 32;
  localparam int VOLT_BITS = 12;
  localparam int LIM_BITS  = 14;
  localparam int PER_BITS  = 16;
  localparam int PCT_BITS  = 8;
  localparam int CMD_BITS  = 21;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 5;

  localparam logic [ADC_BITS-1:0]  ADC_MAX      = {ADC_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] ARM_GAP_MS   = TIME_BITS'(250);
  localparam logic [TIME_BITS-1:0] STOP_HOLD_MS = TIME_BITS'(1000);
  localparam logic [19:0]          CMD_LIMIT    = 20'd1000000;

  // Register indexes (word address bits [4:2]).
  localparam logic [2:0] REG_MAP_LOW       = 3'd0;
  localparam logic [2:0] REG_MAP_HIGH      = 3'd1;
  localparam logic [2:0] REG_NEUTRAL_BAND  = 3'd2;
  localparam logic [2:0] REG_SAFE_LOW      = 3'd3;
  localparam logic [2:0] REG_SAFE_HIGH     = 3'd4;
  localparam logic [2:0] REG_VOLTAGE_FLOOR = 3'd5;
  localparam logic [2:0] REG_FULL_SCALE    = 3'd6;
  localparam logic [2:0] REG_SEND_PERIOD   = 3'd7;

  localparam logic [ADC_BITS-1:0] RST_MAP_LOW      = ADC_BITS'(53);
  localparam logic [ADC_BITS-1:0] RST_MAP_HIGH     = ADC_BITS'(833);
  localparam logic [ADC_BITS-1:0] RST_NEUTRAL_BAND = ADC_BITS'(100);
  localparam logic [ADC_BITS-1:0] RST_SAFE_LOW     = ADC_BITS'(23);
  localparam logic [ADC_BITS-1:0] RST_SAFE_HIGH    = ADC_BITS'(923);

  localparam logic [6:0] PCT_FULL   = 7'd100;
  localparam logic [6:0] START_STOP = 7'd15;
  localparam logic [6:0] START_RUN  = 7'd5;

endpackage

[src/throttle_to_motor_current_unit.sv]
// Throttle sample to signed motor current command, with arming and send rate limiting.
//
// Input channel in_*: one word per timestamped throttle sample. Output channel
// out_*: exactly one result word per input word, in order. Configuration goes
// through the APB-style cfg_* port, eight registers at byte addresses 0 to 28,
// the user must keep them written only while the block is idle; it does not enforce it.
//
// Each word walks a small sequencer: window and neutral checks, the span
// product, three time-difference steps sharing one 32-bit subtractor, the
// send slot update, a 17-step restoring divider for the percentage map,
// then the current scaling. The result register loads as the sequencer
// returns to idle and in_tready rises with it, so the block takes no new word
// before the last one is through; the divider steps make up most of the sequence.
//
// in_tready is high only while the sequencer is idle. A finished result may
// wait in the output register while the next word is accepted; if the
// receiver still holds off when the following result is ready, the
// sequencer waits in its last step until the register is free.
// Reset (rst_n low, synchronous) restores the register defaults, puts the
// block in arming mode and empties the output register.
module throttle_to_motor_current_unit
  import tmc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] now_ms, [41:32] throttle_adc, [42] reverse_level, [54:43] bus_voltage
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [20:0] current_command, [21] send_now, [29:22] throttle_percent,
  // [30] running, [31] reverse_selected, [32] fault
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ARM   = 4'd3;
  localparam logic [3:0] S_STOP  = 4'd4;
  localparam logic [3:0] S_SEND  = 4'd5;
  localparam logic [3:0] S_SNDUP = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_PCT   = 4'd8;
  localparam logic [3:0] S_SCALE = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam int NUM_BITS = ADC_BITS + 7;
  localparam logic [4:0] DIV_LAST = 5'(NUM_BITS - 1);

  // Configuration registers.
  logic [ADC_BITS-1:0]  map_low_r, map_high_r, neutral_band_r, safe_low_r, safe_high_r;
  logic [VOLT_BITS-1:0] voltage_floor_r;
  logic [LIM_BITS-1:0]  full_scale_r;
  logic [PER_BITS-1:0]  send_period_r;

  // Block state.
  logic                 run_mode_r, first_taken_r, first_ok_r, reverse_latch_r;
  logic                 recently_stopped_r;
  logic [TIME_BITS-1:0] first_time_r, stop_time_r, last_send_r;

  // Per-word working registers.
  logic [3:0]           state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r;
  logic [ADC_BITS-1:0]  angle_r;
  logic                 rev_sel_r;
  logic [VOLT_BITS-1:0] volt_r;
  logic                 win_ok_r, volt_ok_r, neutral_r, map_en_r, crossed_r, send_r;
  logic [ADC_BITS-1:0]  a_off_r, den_r;
  logic [6:0]           span_r, start_r, pct_mag_r;
  logic [ADC_BITS-1:0]  div_rem_r;
  logic [NUM_BITS-1:0]  div_quo_r;
  logic [4:0]           div_cnt_r;
  logic [19:0]          cmd_mag_r;

  // Output register.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic                 cfg_wr;
  logic                 in_acc;
  logic [TIME_BITS-1:0] t_sub, t_diff;
  logic [ADC_BITS:0]    neutral_lim;
  logic [ADC_BITS-1:0]  a_lo, a_cl;
  logic                 win_ok, volt_ok, neutral;
  logic [ADC_BITS:0]    div_trial;
  logic                 div_ge;
  logic [6:0]           quot;
  logic [20:0]          prod;
  logic                 out_free;
  logic [CMD_BITS-1:0]  cmd_out;
  logic [PCT_BITS-1:0]  pct_out;
  logic                 fault_w;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    case (cfg_paddr[4:2])
      REG_MAP_LOW:       cfg_prdata = 32'(map_low_r);
      REG_MAP_HIGH:      cfg_prdata = 32'(map_high_r);
      REG_NEUTRAL_BAND:  cfg_prdata = 32'(neutral_band_r);
      REG_SAFE_LOW:      cfg_prdata = 32'(safe_low_r);
      REG_SAFE_HIGH:     cfg_prdata = 32'(safe_high_r);
      REG_VOLTAGE_FLOOR: cfg_prdata = 32'(voltage_floor_r);
      REG_FULL_SCALE:    cfg_prdata = 32'(full_scale_r);
      REG_SEND_PERIOD:   cfg_prdata = 32'(send_period_r);
      default:           cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_low_r       <= RST_MAP_LOW;
      map_high_r      <= RST_MAP_HIGH;
      neutral_band_r  <= RST_NEUTRAL_BAND;
      safe_low_r      <= RST_SAFE_LOW;
      safe_high_r     <= RST_SAFE_HIGH;
      voltage_floor_r <= '0;
      full_scale_r    <= '0;
      send_period_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_MAP_LOW:       map_low_r       <= cfg_pwdata[ADC_BITS-1:0];
        REG_MAP_HIGH:      map_high_r      <= cfg_pwdata[ADC_BITS-1:0];
        REG_NEUTRAL_BAND:  neutral_band_r  <= cfg_pwdata[ADC_BITS-1:0];
        REG_SAFE_LOW:      safe_low_r      <= cfg_pwdata[ADC_BITS-1:0];
        REG_SAFE_HIGH:     safe_high_r     <= cfg_pwdata[ADC_BITS-1:0];
        REG_VOLTAGE_FLOOR: voltage_floor_r <= cfg_pwdata[VOLT_BITS-1:0];
        REG_FULL_SCALE:    full_scale_r    <= cfg_pwdata[LIM_BITS-1:0];
        REG_SEND_PERIOD:   send_period_r   <= cfg_pwdata[PER_BITS-1:0];
        default:           ;
      endcase
    end
  end

  // Checks on the captured sample; the neutral sum carries one extra bit.
  assign neutral_lim = {1'b0, map_low_r} + {1'b0, neutral_band_r};
  assign win_ok      = (angle_r >= safe_low_r) && (angle_r <= safe_high_r);
  assign volt_ok     = volt_r > voltage_floor_r;
  assign neutral     = {1'b0, angle_r} < neutral_lim;
  assign a_lo        = (angle_r < map_low_r) ? map_low_r : angle_r;
  assign a_cl        = (a_lo > map_high_r) ? map_high_r : a_lo;

  // One subtractor serves all three elapsed-time checks.
  always_comb begin
    case (state_r)
      S_ARM:   t_sub = first_time_r;
      S_STOP:  t_sub = stop_time_r;
      default: t_sub = last_send_r;
    endcase
  end
  assign t_diff = now_r - t_sub;

  // Restoring divider step.
  assign div_trial = {div_rem_r, div_quo_r[NUM_BITS-1]};
  assign div_ge    = div_trial >= {1'b0, den_r};
  assign quot      = (den_r == '0) ? 7'd0 : div_quo_r[6:0];
  assign prod      = 21'(pct_mag_r) * 21'(full_scale_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_CHK;
      S_CHK:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ARM;
      S_ARM:   state_nxt = S_STOP;
      S_STOP:  state_nxt = S_SEND;
      S_SEND:  state_nxt = S_SNDUP;
      S_SNDUP: state_nxt = S_DIV;
      S_DIV:   if (div_cnt_r == DIV_LAST) state_nxt = S_PCT;
      S_PCT:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      run_mode_r         <= 1'b0;
      first_taken_r      <= 1'b0;
      first_ok_r         <= 1'b0;
      first_time_r       <= '0;
      reverse_latch_r    <= 1'b0;
      recently_stopped_r <= 1'b1;
      stop_time_r        <= '0;
      last_send_r        <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_ARM: begin
          if (!run_mode_r) begin
            if (!first_taken_r) begin
              first_taken_r <= 1'b1;
              first_time_r  <= now_r;
              first_ok_r    <= win_ok_r && neutral_r;
            end else if (t_diff >= ARM_GAP_MS) begin
              if (first_ok_r && win_ok_r && neutral_r && volt_ok_r) begin
                run_mode_r    <= 1'b1;
                first_taken_r <= 1'b0;
              end else begin
                first_time_r <= now_r;
                first_ok_r   <= win_ok_r && neutral_r;
              end
            end
          end else if (!map_en_r) begin
            run_mode_r    <= 1'b0;
            first_taken_r <= 1'b0;
          end else if (neutral_r) begin
            reverse_latch_r <= rev_sel_r;
          end
        end
        S_STOP: begin
          if (map_en_r) begin
            if (neutral_r) begin
              recently_stopped_r <= 1'b1;
              stop_time_r        <= now_r;
            end else if (t_diff > STOP_HOLD_MS) begin
              recently_stopped_r <= 1'b0;
            end
          end
        end
        S_SNDUP: begin
          if (send_r) last_send_r <= last_send_r + TIME_BITS'(send_period_r);
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; they need no reset.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        now_r     <= in_tdata[TIME_BITS-1:0];
        angle_r   <= ADC_MAX - in_tdata[TIME_BITS +: ADC_BITS];
        rev_sel_r <= !in_tdata[TIME_BITS+ADC_BITS];
        volt_r    <= in_tdata[TIME_BITS+ADC_BITS+1 +: VOLT_BITS];
      end
      S_CHK: begin
        win_ok_r  <= win_ok;
        volt_ok_r <= volt_ok;
        neutral_r <= neutral;
        // Mapping applies only to a clean sample that arrives while running.
        map_en_r  <= run_mode_r && win_ok && volt_ok;
        crossed_r <= map_high_r < map_low_r;
        a_off_r   <= a_cl - map_low_r;
        den_r     <= map_high_r - map_low_r;
        start_r   <= recently_stopped_r ? START_STOP : START_RUN;
        span_r    <= PCT_FULL - (recently_stopped_r ? START_STOP : START_RUN);
      end
      S_MUL: begin
        div_quo_r <= NUM_BITS'(a_off_r) * NUM_BITS'(span_r);
        div_rem_r <= '0;
        div_cnt_r <= '0;
      end
      S_SEND: send_r <= t_diff >= TIME_BITS'(send_period_r);
      S_DIV: begin
        div_rem_r <= div_ge ? ADC_BITS'(div_trial - {1'b0, den_r})
                            : div_trial[ADC_BITS-1:0];
        div_quo_r <= {div_quo_r[NUM_BITS-2:0], div_ge};
        div_cnt_r <= div_cnt_r + 5'd1;
      end
      S_PCT: begin
        if (!map_en_r || neutral_r) pct_mag_r <= 7'd0;
        else if (crossed_r)         pct_mag_r <= PCT_FULL;
        else                        pct_mag_r <= start_r + quot;
      end
      S_SCALE: cmd_mag_r <= (prod > 21'(CMD_LIMIT)) ? CMD_LIMIT : prod[19:0];
      default: ;
    endcase
  end

  assign cmd_out = reverse_latch_r ? CMD_BITS'(-{1'b0, cmd_mag_r}) : {1'b0, cmd_mag_r};
  assign pct_out = reverse_latch_r ? PCT_BITS'(-{1'b0, pct_mag_r}) : {1'b0, pct_mag_r};
  assign fault_w = !win_ok_r || !volt_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {7'd0, fault_w, reverse_latch_r, run_mode_r, pct_out, send_r, cmd_out};
    end
  end

endmodule

[src/tmc_checker.sv]
// Port-level checker for the throttle to motor current unit, bound to the top level.
module tmc_checker
  import tmc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic signed [PCT_BITS-1:0] pct;
  logic [CMD_BITS-1:0]        cmd;

  assign pct = out_tdata[29:22];
  assign cmd = out_tdata[20:0];

  // A result word on hold keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // The sequencer is busy after taking a word, so it never accepts words back to back.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // Arming mode and faulted samples command no current and no throttle.
  a_arming_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (!out_tdata[30] || out_tdata[32]) |-> cmd == '0 && pct == '0)
    else $error("nonzero command outside running mode");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pct <= 8'sd100 && pct >= -8'sd100)
    else $error("throttle percentage out of range");

  // A zero percentage always gives a zero command.
  a_pct_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && pct == '0 |-> cmd == '0)
    else $error("command without throttle");

endmodule

bind throttle_to_motor_current_unit tmc_checker u_tmc_checker (.*);
